FILE: hdl/pclc_pkg.sv
// ----------------------------------------------------------------------------
// pclc_pkg
// Types and constants for the pedestrian crossing light controller: phase and
// walk codes, lamp patterns, register indexes and the 7-segment decoder.
// ----------------------------------------------------------------------------
package pclc_pkg;

    // Vehicle light phases; code three is unused and treated as red
    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2
    } t_phase;

    // Which crossing is currently walking
    typedef enum logic [1:0] {
        WALK_NONE = 2'd0,
        WALK_ONE  = 2'd1,
        WALK_TWO  = 2'd2
    } t_walk;

    // Vehicle lamp patterns: bit0 green, bit1 yellow, bit2 red
    localparam logic [2:0] LAMP_OFF    = 3'b000;
    localparam logic [2:0] LAMP_GREEN  = 3'b001;
    localparam logic [2:0] LAMP_YELLOW = 3'b010;
    localparam logic [2:0] LAMP_RED    = 3'b100;

    // Walk lamp patterns: bit0 walk green, bit1 walk red
    localparam logic [1:0] WLAMP_GO   = 2'b01;
    localparam logic [1:0] WLAMP_STOP = 2'b10;

    // Configuration register indexes (byte address = 4 * index)
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_GREEN       = 3'd0;
    localparam logic [2:0] REG_BLINK_START = 3'd1;
    localparam logic [2:0] REG_YELLOW      = 3'd2;
    localparam logic [2:0] REG_RED         = 3'd3;
    localparam logic [2:0] REG_CD_PERIOD   = 3'd4;
    localparam logic [2:0] REG_CD_START    = 3'd5;

    // Register reset values
    localparam logic [9:0]  RST_GREEN       = 10'd800;
    localparam logic [9:0]  RST_BLINK_START = 10'd650;
    localparam logic [9:0]  RST_YELLOW      = 10'd200;
    localparam logic [9:0]  RST_RED         = 10'd800;
    localparam logic [15:0] RST_CD_PERIOD   = 16'd400;
    localparam logic [3:0]  RST_CD_START    = 4'd9;

    // Largest countdown digit
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // Decode a digit to segments a (bit0) .. g (bit6)
    function automatic logic [6:0] f_seg(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            default: seg = 7'h6F;
        endcase
        return seg;
    endfunction

endpackage

FILE: hdl/pedestrian_crossing_light_controller.sv
// ----------------------------------------------------------------------------
// pedestrian_crossing_light_controller
// Two vehicle lights and two walk lights. Each input transfer is one tick
// carrying the walk buttons; each tick yields one transfer of lamp states,
// countdown digit segments and display enables.
// ----------------------------------------------------------------------------
// The result is registered: output valid rises in the cycle after the input transfer.
// Throughput: one tick per cycle while the output is not stalled; the output register
// lets a new tick be taken in the same cycle the held result is taken.
// Reset (i_rst_n low, synchronous): light one green, light two red, no
// crossing walking, timebase cleared, registers back to their defaults.
module pedestrian_crossing_light_controller #(
    parameter int unsigned BLINK_PERIOD = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Tick input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_request_one,
    input  logic                         i_request_two,
    // Result output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_vehicle_one_lamps,
    output logic [2:0]                   o_vehicle_two_lamps,
    output logic [1:0]                   o_walk_one_lamps,
    output logic [1:0]                   o_walk_two_lamps,
    output logic [6:0]                   o_segment_pattern,
    output logic [1:0]                   o_display_enables,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pclc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pclc_pkg::*;

    localparam int unsigned BLINK_W = (BLINK_PERIOD > 2) ? $clog2(BLINK_PERIOD) : 1;
    localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_PERIOD - 1);
    localparam logic [BLINK_W-1:0] BLINK_HALF = BLINK_W'(BLINK_PERIOD / 2);

    // Configuration registers
    logic [9:0]  r_green;
    logic [9:0]  r_blink_start;
    logic [9:0]  r_yellow;
    logic [9:0]  r_red;
    logic [15:0] r_cd_period;
    logic [3:0]  r_cd_start;

    // Controller state; r_blink tracks phase time modulo the blink period
    t_phase               r_phase [2];
    logic [9:0]           r_time  [2];
    logic [BLINK_W-1:0]   r_blink [2];
    t_walk                r_walk;
    logic [3:0]           r_digit;
    logic                 r_running;
    logic [15:0]          r_tb;

    t_phase               n_phase [2];
    logic [9:0]           n_time  [2];
    logic [BLINK_W-1:0]   n_blink [2];
    t_walk                n_walk;
    logic [3:0]           n_digit;
    logic                 n_running;
    logic [15:0]          n_tb;

    // Result register
    logic                 r_out_valid;
    logic [2:0]           r_veh_lamps [2];
    logic [2:0]           n_veh_lamps [2];
    logic [1:0]           r_walk_one;
    logic [1:0]           r_walk_two;
    logic [6:0]           r_seg;
    logic [1:0]           r_disp;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green       <= RST_GREEN;
            r_blink_start <= RST_BLINK_START;
            r_yellow      <= RST_YELLOW;
            r_red         <= RST_RED;
            r_cd_period   <= RST_CD_PERIOD;
            r_cd_start    <= RST_CD_START;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GREEN:       r_green       <= pwdata[9:0];
                REG_BLINK_START: r_blink_start <= pwdata[9:0];
                REG_YELLOW:      r_yellow      <= pwdata[9:0];
                REG_RED:         r_red         <= pwdata[9:0];
                REG_CD_PERIOD:   r_cd_period   <= pwdata[15:0];
                REG_CD_START:    r_cd_start    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (cfg_idx)
            REG_GREEN:       prdata = {22'd0, r_green};
            REG_BLINK_START: prdata = {22'd0, r_blink_start};
            REG_YELLOW:      prdata = {22'd0, r_yellow};
            REG_RED:         prdata = {22'd0, r_red};
            REG_CD_PERIOD:   prdata = {16'd0, r_cd_period};
            REG_CD_START:    prdata = {28'd0, r_cd_start};
            default:         prdata = 32'd0;
        endcase
    end

    // Next state for one tick: request, timebase, lights, lamps
    always_comb begin
        logic [9:0]         t1;
        logic [BLINK_W-1:0] m1;
        logic [9:0]         limit;
        logic [15:0]        tb1;
        t_walk              own;

        n_phase   = r_phase;
        n_time    = r_time;
        n_blink   = r_blink;
        n_walk    = r_walk;
        n_digit   = r_digit;
        n_running = r_running;

        // Start a walk on a button press, crossing one wins ties
        if (r_walk == WALK_NONE && (i_request_one || i_request_two)) begin
            n_running = 1'b1;
            n_digit   = (r_cd_start > DIGIT_MAX) ? DIGIT_MAX : r_cd_start;
            if (i_request_one) begin
                n_walk     = WALK_ONE;
                n_phase[0] = PH_RED;
                n_time[0]  = '0;
                n_blink[0] = '0;
            end else begin
                n_walk     = WALK_TWO;
                n_phase[1] = PH_RED;
                n_time[1]  = '0;
                n_blink[1] = '0;
            end
        end

        // Step the timebase and the countdown
        tb1  = r_tb + 16'd1;
        n_tb = tb1;
        if (tb1 >= r_cd_period) begin
            n_tb = '0;
            if (n_running) begin
                if (n_digit != 4'd0) begin
                    n_digit = n_digit - 4'd1;
                end else begin
                    if (n_walk == WALK_ONE) begin
                        n_phase[0] = PH_GREEN;
                        n_time[0]  = '0;
                        n_blink[0] = '0;
                    end else if (n_walk == WALK_TWO) begin
                        n_phase[1] = PH_GREEN;
                        n_time[1]  = '0;
                        n_blink[1] = '0;
                    end
                    n_running = 1'b0;
                    n_walk    = WALK_NONE;
                end
            end
        end

        // Advance each light not held by its walking crossing
        for (int k = 0; k < 2; k++) begin
            own = (k == 0) ? WALK_ONE : WALK_TWO;
            t1  = n_time[k] + 10'd1;
            if (t1 == 10'd0 || n_blink[k] == BLINK_LAST) begin
                m1 = '0;
            end else begin
                m1 = n_blink[k] + BLINK_W'(1);
            end
            case (n_phase[k])
                PH_GREEN:  limit = r_green;
                PH_YELLOW: limit = r_yellow;
                default:   limit = r_red;
            endcase
            if (n_walk != own) begin
                if (t1 >= limit) begin
                    case (n_phase[k])
                        PH_GREEN:  n_phase[k] = PH_YELLOW;
                        PH_YELLOW: n_phase[k] = PH_RED;
                        default:   n_phase[k] = PH_GREEN;
                    endcase
                    n_time[k]  = '0;
                    n_blink[k] = '0;
                end else begin
                    n_time[k]  = t1;
                    n_blink[k] = m1;
                end
            end

            // Vehicle lamps, blinking green late in the phase
            case (n_phase[k])
                PH_GREEN: begin
                    if (n_time[k] >= r_blink_start && n_blink[k] >= BLINK_HALF) begin
                        n_veh_lamps[k] = LAMP_OFF;
                    end else begin
                        n_veh_lamps[k] = LAMP_GREEN;
                    end
                end
                PH_YELLOW: n_veh_lamps[k] = LAMP_YELLOW;
                default:   n_veh_lamps[k] = LAMP_RED;
            endcase
        end
    end

    // Commit state on each tick transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase[0] <= PH_GREEN;
            r_phase[1] <= PH_RED;
            r_time[0]  <= '0;
            r_time[1]  <= '0;
            r_blink[0] <= '0;
            r_blink[1] <= '0;
            r_walk     <= WALK_NONE;
            r_digit    <= '0;
            r_running  <= 1'b0;
            r_tb       <= '0;
        end else if (in_xfer) begin
            r_phase   <= n_phase;
            r_time    <= n_time;
            r_blink   <= n_blink;
            r_walk    <= n_walk;
            r_digit   <= n_digit;
            r_running <= n_running;
            r_tb      <= n_tb;
        end
    end

    // Hold output valid until the result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_veh_lamps <= n_veh_lamps;
            r_walk_one  <= (n_walk == WALK_ONE) ? WLAMP_GO : WLAMP_STOP;
            r_walk_two  <= (n_walk == WALK_TWO) ? WLAMP_GO : WLAMP_STOP;
            r_seg       <= n_running ? f_seg(n_digit) : 7'd0;
            r_disp      <= n_running ? n_walk : 2'd0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_vehicle_one_lamps = r_veh_lamps[0];
    assign o_vehicle_two_lamps = r_veh_lamps[1];
    assign o_walk_one_lamps    = r_walk_one;
    assign o_walk_two_lamps    = r_walk_two;
    assign o_segment_pattern   = r_seg;
    assign o_display_enables   = r_disp;

endmodule
